[hw/rtl/ipv4s_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ipv4s_pkg;

	localparam int unsigned LEN_W = 5;
	localparam logic [LEN_W-1:0] RUN_LEN_MAX_SAT = 5'd31;
	localparam logic [LEN_W-1:0] MIN_RUN_LEN = 5'd7;
	localparam logic [LEN_W-1:0] MAX_RUN_LEN = 5'd15;

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [7:0] CHAR_DOT = 8'h2E;

	localparam logic [7:0] LOOPBACK_OCTET = 8'd127;
	localparam logic [7:0] MCAST_LO_OCTET = 8'd224;
	localparam logic [7:0] MCAST_HI_OCTET = 8'd239;
	localparam logic [31:0] ALL_ONES_ADDR = 32'hFFFF_FFFF;
	localparam logic [1:0] LAST_OCTET_IDX = 2'd3;
	localparam logic [1:0] MAX_DIGITS = 2'd3;
	localparam logic [11:0] OCTET_MAX = 12'd255;

	typedef struct packed {
		logic        in_run;
		logic        run_invalid;
		logic [4:0]  run_length;
		logic [1:0]  octet_index;
		logic [7:0]  octet_value;
		logic [1:0]  octet_digits;
		logic        octet_leading_zero;
		logic [23:0] upper_octets;
		logic        have_result;
		logic [31:0] result_address;
	} scan_state_t;

	typedef struct packed {
		logic        valid;
		logic        found;
		logic [31:0] address;
	} scan_result_t;

endpackage

`default_nettype wire

[hw/rtl/ipv4s_step.sv]
`timescale 1ns / 1ps
`default_nettype none

module ipv4s_step (
	input  wire ipv4s_pkg::scan_state_t  cur,
	input  wire logic [7:0]              text_byte,
	input  wire logic                    line_end,
	output ipv4s_pkg::scan_state_t       nxt,
	output ipv4s_pkg::scan_result_t      res
);

	// Score a finished run, then clear the run fields.
	function automatic ipv4s_pkg::scan_state_t close_run(input ipv4s_pkg::scan_state_t s);
		ipv4s_pkg::scan_state_t r;
		logic [31:0] a;
		logic        usable;
		logic        skip;
		r = s;
		a = {s.upper_octets, s.octet_value};
		usable = s.in_run && !s.run_invalid && (s.octet_digits != 2'd0) &&
			(s.octet_index == ipv4s_pkg::LAST_OCTET_IDX) &&
			(s.run_length >= ipv4s_pkg::MIN_RUN_LEN) &&
			(s.run_length <= ipv4s_pkg::MAX_RUN_LEN) && !s.have_result;
		skip = (a == 32'd0) || (a == ipv4s_pkg::ALL_ONES_ADDR) ||
			(a[31:24] == ipv4s_pkg::LOOPBACK_OCTET) ||
			((a[31:24] >= ipv4s_pkg::MCAST_LO_OCTET) &&
			 (a[31:24] <= ipv4s_pkg::MCAST_HI_OCTET));
		if (usable && !skip) begin
			r.have_result = 1'b1;
			r.result_address = a;
		end
		r.in_run = 1'b0;
		r.run_invalid = 1'b0;
		r.run_length = '0;
		r.octet_index = '0;
		r.octet_value = '0;
		r.octet_digits = '0;
		r.octet_leading_zero = 1'b0;
		r.upper_octets = '0;
		return r;
	endfunction

	logic        is_digit;
	logic        is_run_byte;
	logic [3:0]  digit;
	logic [11:0] acc;
	logic        digit_bad;
	logic        dot_bad;
	ipv4s_pkg::scan_state_t took;
	ipv4s_pkg::scan_state_t fin;

	assign is_digit = (text_byte >= ipv4s_pkg::CHAR_ZERO) && (text_byte <= ipv4s_pkg::CHAR_NINE);
	assign is_run_byte = is_digit || (text_byte == ipv4s_pkg::CHAR_DOT);
	assign digit = text_byte[3:0];
	// value * 10 + digit as shift-and-add
	assign acc = {1'b0, cur.octet_value, 3'b000} + {3'b000, cur.octet_value, 1'b0} +
		{8'd0, digit};
	assign digit_bad = (cur.octet_digits >= ipv4s_pkg::MAX_DIGITS) ||
		((cur.octet_digits != 2'd0) && cur.octet_leading_zero) || (acc > ipv4s_pkg::OCTET_MAX);
	assign dot_bad = (cur.octet_digits == 2'd0) || (cur.octet_index >= ipv4s_pkg::LAST_OCTET_IDX);

	always_comb begin
		took = cur;
		if (!cur.in_run) begin
			took.in_run = 1'b1;
			took.run_invalid = !is_digit;
		end
		if (cur.run_length < ipv4s_pkg::RUN_LEN_MAX_SAT) begin
			took.run_length = cur.run_length + 5'd1;
		end
		if (!took.run_invalid) begin
			if (is_digit) begin
				if (digit_bad) begin
					took.run_invalid = 1'b1;
				end else begin
					took.octet_leading_zero = (cur.octet_digits == 2'd0) && (digit == 4'd0);
					took.octet_value = acc[7:0];
					took.octet_digits = cur.octet_digits + 2'd1;
				end
			end else begin
				if (dot_bad) begin
					took.run_invalid = 1'b1;
				end else begin
					took.upper_octets = {cur.upper_octets[15:0], cur.octet_value};
					took.octet_index = cur.octet_index + 2'd1;
					took.octet_value = '0;
					took.octet_digits = '0;
					took.octet_leading_zero = 1'b0;
				end
			end
		end

		fin = is_run_byte ? took : close_run(cur);
		if (line_end) begin
			fin = close_run(fin);
		end

		res.valid = line_end;
		res.found = fin.have_result;
		res.address = fin.have_result ? fin.result_address : 32'd0;

		nxt = fin;
		if (line_end) begin
			nxt.have_result = 1'b0;
			nxt.result_address = '0;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/ipv4s_out.sv]
`timescale 1ns / 1ps
`default_nettype none

module ipv4s_out (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          load,
	input  wire ipv4s_pkg::scan_result_t res,
	input  wire logic                    out_stall,
	output logic                         out_valid,
	output logic                         found,
	output logic [31:0]                  address
);

	logic        valid_q;
	logic        found_q;
	logic [31:0] address_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// Payload holds while stalled; load is only raised when the slot frees.
	always_ff @(posedge clk) begin
		if (load) begin
			found_q <= res.found;
			address_q <= res.address;
		end
	end

	assign out_valid = valid_q;
	assign found = found_q;
	assign address = address_q;

endmodule

`default_nettype wire

[hw/rtl/ipv4_address_text_scanner_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// A line's result is registered in the output slot once its last byte leaves the input register.
// Throughput: one text byte per cycle while in_stall is low; the per-byte scan update sits between the
// input register and the scan state / result registers.
// Input stalls only when a line end waits in the input register behind an untaken result.
// Reset (arst_n low, asynchronous): clears the scan state and both valid flags at once.

module ipv4_address_text_scanner_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [7:0]  text_byte,
	input  wire         line_end,
	output logic        out_valid,
	input  wire         out_stall,
	output logic        found,
	output logic [31:0] address
);

	// Input register: one request deep.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Scan state that carries across bytes of one line.
	ipv4s_pkg::scan_state_t  state_q;
	ipv4s_pkg::scan_state_t  state_nxt;
	ipv4s_pkg::scan_result_t res;

	logic out_busy;
	logic advance;
	logic fire;

	// The output slot is blocked when it holds a result nobody takes this cycle.
	assign out_busy = out_valid && out_stall;
	// Hold the stage only when it would produce a result into a blocked slot.
	assign advance = !(valid_s1 && last_s1 && out_busy);
	assign fire = valid_s1 && advance;
	assign in_stall = !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			byte_s1 <= text_byte;
			last_s1 <= line_end;
		end
	end

	ipv4s_step u_step (
		.cur       (state_q),
		.text_byte (byte_s1),
		.line_end  (last_s1),
		.nxt       (state_nxt),
		.res       (res)
	);

	// Advance the scan state on every byte that leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (fire) begin
			state_q <= state_nxt;
		end
	end

	ipv4s_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire && res.valid),
		.res       (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.found     (found),
		.address   (address)
	);

endmodule

`default_nettype wire
